### src/hsvrgb_pkg.sv
// hsvrgb_pkg: constants, types and widths for the hsv to rgb converter
// no dependencies; imported by the interfaces and every module of the block
package hsvrgb_pkg;

  localparam int HueW = 9;
  localparam int ChanW = 8;
  localparam int KW = 6;                       // sector ramp 0..60
  localparam int InnerW = 14;                  // s*k + 60*(255-s) <= 15300
  localparam int MidNumW = 22;                 // v * inner <= 3901500
  localparam int BotNumW = 16;                 // v * (255-s) <= 65025
  localparam int RecipW = 17;

  localparam logic [HueW-1:0] SectorDeg = 9'd60;
  localparam logic [ChanW-1:0] FullScale = 8'd255;
  localparam logic [HueW-1:0] HalfTurnDeg = 9'd120;
  localparam logic [InnerW-1:0] MidDivisor = 14'd15300;   // 255 * 60

  // floor(2^30 / 15300) and floor(2^24 / 255); estimate is exact or one low
  localparam logic [RecipW-1:0] MidRecip = 17'd70179;
  localparam int MidShift = 30;
  localparam logic [RecipW-1:0] BotRecip = 17'd65793;
  localparam int BotShift = 24;

  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5,
    SEC_GREY     = 3'd6
  } sector_t;

  // side data that rides along the divider stages
  typedef struct packed {
    sector_t          sector;
    logic [ChanW-1:0] top;
  } pix_tag_t;

endpackage

### src/hsvrgb_hsv_if.sv
// hsvrgb_hsv_if: valid/ready channel carrying one hsv pixel request
// depends on hsvrgb_pkg for field widths
interface hsvrgb_hsv_if import hsvrgb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] saturation;
  logic [ChanW-1:0] value;

  modport source (output valid, hue, saturation, value, input ready);
  modport sink (input valid, hue, saturation, value, output ready);
endinterface

### src/hsvrgb_rgb_if.sv
// hsvrgb_rgb_if: valid/ready channel carrying one rgb pixel request
// depends on hsvrgb_pkg for field widths
interface hsvrgb_rgb_if import hsvrgb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

### src/hsv_to_rgb_converter_unit.sv
// hsv_to_rgb_converter_unit: pipelined hsv to rgb pixel converter, top level
// depends on hsvrgb_pkg, hsvrgb_hsv_if, hsvrgb_rgb_if and hsvrgb_div
//
// usage
//   hsv : sink channel, one pixel request (hue in degrees 0..359, saturation
//         and value as 8-bit fractions) taken when valid and ready are high
//   rgb : source channel, one red/green/blue request per pixel, in order
//   hue of 360 and above gives grey: every channel is v*(255-s)/255
// timing
//   six register stages: sector decode, inner product, scale by value,
//   reciprocal estimate, correction, channel routing into the output register
//   a pixel accepted at one edge moves through these registers in order and
//   then shows on rgb; a stall on rgb holds it in place
//   one pixel per clock sustained while rgb does not stall; the two multiplier
//   stages and the divider estimate stage set the per-stage depth
// reset and stall
//   rst (synchronous) clears every stage valid bit; payload is not reset
//   when rgb is stalled with a result waiting, the whole pipe holds;
//   hsv.ready drops only then, so nothing is lost or repeated
module hsv_to_rgb_converter_unit import hsvrgb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  hsvrgb_hsv_if.sink    hsv,
  hsvrgb_rgb_if.source  rgb
);

  // global advance: the output register is free or being drained
  logic en;
  logic out_valid;
  logic [ChanW-1:0] out_red;
  logic [ChanW-1:0] out_green;
  logic [ChanW-1:0] out_blue;

  assign en        = !out_valid || rgb.ready;
  assign hsv.ready = en;
  assign rgb.valid = out_valid;
  assign rgb.red   = out_red;
  assign rgb.green = out_green;
  assign rgb.blue  = out_blue;

  // ---------------- stage 1: sector and ramp decode ----------------
  sector_t          sector_next;
  logic [HueW-1:0]  half_base;
  logic [HueW-1:0]  rem120;
  logic [HueW-1:0]  ramp_dist;
  logic [KW-1:0]    k_next;

  always_comb begin
    if (hsv.hue >= 9'd360)      sector_next = SEC_GREY;
    else if (hsv.hue >= 9'd300) sector_next = SEC_MAG_RED;
    else if (hsv.hue >= 9'd240) sector_next = SEC_BLU_MAG;
    else if (hsv.hue >= 9'd180) sector_next = SEC_CYN_BLU;
    else if (hsv.hue >= 9'd120) sector_next = SEC_GRN_CYN;
    else if (hsv.hue >= 9'd60)  sector_next = SEC_YEL_GRN;
    else                        sector_next = SEC_RED_YEL;
  end

  // position within the current 120 degree half turn
  always_comb begin
    case (sector_next)
      SEC_GRN_CYN, SEC_CYN_BLU: half_base = HalfTurnDeg;
      SEC_BLU_MAG, SEC_MAG_RED: half_base = HalfTurnDeg + HalfTurnDeg;
      default:                  half_base = '0;
    endcase
  end

  assign rem120    = hsv.hue - half_base;
  assign ramp_dist = (rem120 >= SectorDeg) ? rem120 - SectorDeg : SectorDeg - rem120;
  assign k_next    = KW'(SectorDeg - ramp_dist);

  logic             s1_valid;
  sector_t          s1_sector;
  logic [KW-1:0]    s1_k;
  logic [ChanW-1:0] s1_sat;
  logic [ChanW-1:0] s1_nsat;
  logic [ChanW-1:0] s1_val;

  // ---------------- stage 2: inner blend and bottom product ----------------
  logic [InnerW-1:0]  inner_next;
  logic [BotNumW-1:0] bot_num_next;

  assign inner_next = InnerW'(s1_sat) * InnerW'(s1_k)
                    + InnerW'(SectorDeg) * InnerW'(s1_nsat);
  assign bot_num_next = BotNumW'(s1_val) * BotNumW'(s1_nsat);

  logic               s2_valid;
  sector_t            s2_sector;
  logic [InnerW-1:0]  s2_inner;
  logic [BotNumW-1:0] s2_bot_num;
  logic [ChanW-1:0]   s2_val;

  // ---------------- stage 3: scale blend by value ----------------
  logic [MidNumW-1:0] mid_num_next;

  assign mid_num_next = MidNumW'(s2_val) * MidNumW'(s2_inner);

  logic               s3_valid;
  pix_tag_t           s3_tag;
  logic [MidNumW-1:0] s3_mid_num;
  logic [BotNumW-1:0] s3_bot_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= hsv.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    if (en) begin
      s1_sector     <= sector_next;
      s1_k          <= k_next;
      s1_sat        <= hsv.saturation;
      s1_nsat       <= FullScale - hsv.saturation;
      s1_val        <= hsv.value;
      s2_sector     <= s1_sector;
      s2_inner      <= inner_next;
      s2_bot_num    <= bot_num_next;
      s2_val        <= s1_val;
      s3_tag.sector <= s2_sector;
      s3_tag.top    <= s2_val;
      s3_mid_num    <= mid_num_next;
      s3_bot_num    <= s2_bot_num;
    end
  end

  // ---------------- stages 4 and 5: constant dividers ----------------
  logic             d_valid;
  pix_tag_t         d_tag;
  logic [ChanW-1:0] d_mid;
  logic [ChanW-1:0] d_bot;

  hsvrgb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .in_tag    (s3_tag),
    .mid_num   (s3_mid_num),
    .bot_num   (s3_bot_num),
    .out_valid (d_valid),
    .out_tag   (d_tag),
    .mid_q     (d_mid),
    .bot_q     (d_bot)
  );

  // ---------------- stage 6: channel routing ----------------
  logic [ChanW-1:0] red_next;
  logic [ChanW-1:0] green_next;
  logic [ChanW-1:0] blue_next;

  always_comb begin
    case (d_tag.sector)
      SEC_RED_YEL: begin
        red_next = d_tag.top; green_next = d_mid;     blue_next = d_bot;
      end
      SEC_YEL_GRN: begin
        red_next = d_mid;     green_next = d_tag.top; blue_next = d_bot;
      end
      SEC_GRN_CYN: begin
        red_next = d_bot;     green_next = d_tag.top; blue_next = d_mid;
      end
      SEC_CYN_BLU: begin
        red_next = d_bot;     green_next = d_mid;     blue_next = d_tag.top;
      end
      SEC_BLU_MAG: begin
        red_next = d_mid;     green_next = d_bot;     blue_next = d_tag.top;
      end
      SEC_MAG_RED: begin
        red_next = d_tag.top; green_next = d_bot;     blue_next = d_mid;
      end
      default: begin
        // grey: all channels at the offset
        red_next = d_bot;     green_next = d_bot;     blue_next = d_bot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
    if (en) begin
      out_red   <= red_next;
      out_green <= green_next;
      out_blue  <= blue_next;
    end
  end

endmodule

### src/hsvrgb_div.sv
// hsvrgb_div: two-stage constant dividers, mid part by 15300 and bottom part by 255
// reciprocal multiply then one compare-and-correct step; depends on hsvrgb_pkg
module hsvrgb_div import hsvrgb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  pix_tag_t           in_tag,
  input  logic [MidNumW-1:0] mid_num,
  input  logic [BotNumW-1:0] bot_num,
  output logic               out_valid,
  output pix_tag_t           out_tag,
  output logic [ChanW-1:0]   mid_q,
  output logic [ChanW-1:0]   bot_q
);

  localparam int MidProdW = MidNumW + RecipW;
  localparam int BotProdW = BotNumW + RecipW;

  // estimate stage
  logic               est_valid;
  pix_tag_t           est_tag;
  logic [MidNumW-1:0] est_mid_num;
  logic [BotNumW-1:0] est_bot_num;
  logic [ChanW-1:0]   est_mid_q;
  logic [ChanW-1:0]   est_bot_q;

  logic [MidProdW-1:0] mid_prod;
  logic [BotProdW-1:0] bot_prod;

  // correction stage
  logic [MidNumW-1:0] mid_rem;
  logic [BotNumW-1:0] bot_rem;
  logic [ChanW-1:0]   mid_q_next;
  logic [ChanW-1:0]   bot_q_next;

  assign mid_prod = MidProdW'(mid_num) * MidProdW'(MidRecip);
  assign bot_prod = BotProdW'(bot_num) * BotProdW'(BotRecip);

  assign mid_rem = est_mid_num - MidNumW'(est_mid_q) * MidNumW'(MidDivisor);
  assign bot_rem = est_bot_num - BotNumW'(est_bot_q) * BotNumW'(FullScale);
  assign mid_q_next = (mid_rem >= MidNumW'(MidDivisor)) ? est_mid_q + 1'b1 : est_mid_q;
  assign bot_q_next = (bot_rem >= BotNumW'(FullScale)) ? est_bot_q + 1'b1 : est_bot_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      est_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      est_valid <= in_valid;
      out_valid <= est_valid;
    end
    if (en) begin
      est_tag     <= in_tag;
      est_mid_num <= mid_num;
      est_bot_num <= bot_num;
      est_mid_q   <= mid_prod[MidShift +: ChanW];
      est_bot_q   <= bot_prod[BotShift +: ChanW];
      out_tag     <= est_tag;
      mid_q       <= mid_q_next;
      bot_q       <= bot_q_next;
    end
  end

endmodule
